// ===== rtl/csws_pkg.sv =====
// Shared types and constants for the sub-rectangle sum counter.
package csws_pkg;

   localparam int GRID_W     = 7;
   localparam int TARGET_W   = 16;
   localparam int DIGIT_W    = 4;
   localparam int COUNT_W    = 23;
   localparam int PREFIX_W   = 16;
   localparam int COLRUN_W   = PREFIX_W + 1;
   localparam int WANT_W     = PREFIX_W + 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SUM = 1'b1;

   localparam logic [GRID_W-1:0]   GRID_RESET   = 7'd64;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_FETCH,
      S_COL,
      S_LO,
      S_HI,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load_read;
      logic load_write;
      logic fetch;
      logic col;
      logic lo_run;
      logic hi_run;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_cell;
      logic lo_step;
      logic hi_step;
      logic pair_end;
      logic sweep_end;
      logic rsp_free;
   } sts_type;

endpackage

// ===== rtl/csws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/csws_ctrl.sv =====
// Controller state machine for loading and the row-pair sweep.
module csws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  csws_pkg::sts_type sts,
   output csws_pkg::cmd_type cmd
);
   import csws_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_WRITE;
         S_WRITE: state_in = sts.last_cell ? S_FETCH : S_IDLE;
         S_FETCH: state_in = S_COL;
         S_COL:   state_in = S_LO;
         S_LO:    if (!sts.lo_step) state_in = S_HI;
         S_HI: begin
            if (!sts.hi_step) begin
               state_in = (sts.pair_end && sts.sweep_end) ? S_DONE : S_FETCH;
            end
         end
         S_DONE:  if (sts.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.load_read  = (state_ff == S_IDLE) && req_valid;
      cmd.load_write = (state_ff == S_WRITE);
      cmd.fetch      = (state_ff == S_FETCH);
      cmd.col        = (state_ff == S_COL);
      cmd.lo_run     = (state_ff == S_LO);
      cmd.hi_run     = (state_ff == S_HI);
      cmd.out_load   = (state_ff == S_DONE) && sts.rsp_free;
   end

   assign req_stall = (state_ff != S_IDLE);

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load_read |=> state_ff == S_WRITE)
      else $error("load read not followed by write");

   a_col_after_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> cmd.col)
      else $error("fetch not followed by column step");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.lo_run || cmd.hi_run || cmd.col) |-> req_stall)
      else $error("request open during sweep");

endmodule

// ===== rtl/csws_dp.sv =====
// Datapath: configuration, prefix table, column runs, pointers and count.
module csws_dp #(
   parameter int GRID_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [csws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csws_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [csws_pkg::DIGIT_W-1:0]        req_cell_digit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [csws_pkg::COUNT_W-1:0]        rsp_match_count,
   input  csws_pkg::cmd_type                   cmd,
   output csws_pkg::sts_type                   sts
);
   import csws_pkg::*;

   localparam int RW = $clog2(GRID_MAX);
   localparam int NW = $clog2(GRID_MAX + 1);
   localparam int AW = 2 * RW;

   logic [GRID_W-1:0]   grid_ff, grid_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [RW-1:0]       row_ff, row_in, col_ff, col_in;
   logic [PREFIX_W-1:0] rowsum_ff, rowsum_in;
   logic [NW-1:0]       b_ff, b_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0]       top_ff, top_in, bot_ff, bot_in;
   logic signed [WANT_W-1:0] want_ff, want_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0]       n;
   logic [AW-1:0]       pa_rd_addr, pb_rd_addr, p_wr_addr;
   logic [PREFIX_W-1:0] pa_rd, pb_rd, p_wr_data;
   logic signed [COLRUN_W-1:0] colrun, lo_rd, hi_rd, lo_val, hi_val;
   logic                lo_step, hi_step, pair_end, sweep_end;

   always_comb begin
      if (grid_ff == '0) begin
         n = NW'(1);
      end else if (int'(grid_ff) > GRID_MAX) begin
         n = NW'(GRID_MAX);
      end else begin
         n = NW'(grid_ff);
      end
   end

   assign pa_rd_addr = cmd.load_read ? {RW'(row_ff - RW'(1)), col_ff}
                                     : {RW'(bot_ff - NW'(1)), RW'(b_ff - NW'(1))};
   assign pb_rd_addr = {RW'(top_ff - NW'(2)), RW'(b_ff - NW'(1))};
   assign p_wr_addr  = {row_ff, col_ff};
   assign p_wr_data  = (row_ff == '0) ? rowsum_ff : PREFIX_W'(rowsum_ff + pa_rd);

   csws_ram #(.WIDTH(PREFIX_W), .DEPTH(2 ** AW)) u_prefix_a (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_addr (pa_rd_addr),
      .rd_data (pa_rd)
   );

   csws_ram #(.WIDTH(PREFIX_W), .DEPTH(2 ** AW)) u_prefix_b (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_addr (pb_rd_addr),
      .rd_data (pb_rd)
   );

   assign colrun = (top_ff == NW'(1))
                 ? $signed({1'b0, pa_rd})
                 : $signed({1'b0, pa_rd}) - $signed({1'b0, pb_rd});

   csws_ram #(.WIDTH(COLRUN_W), .DEPTH(2 ** NW)) u_run_lo (
      .clock   (clock),
      .wr_en   (cmd.col),
      .wr_addr (b_ff),
      .wr_data (colrun),
      .rd_addr (lo_in),
      .rd_data (lo_rd)
   );

   csws_ram #(.WIDTH(COLRUN_W), .DEPTH(2 ** NW)) u_run_hi (
      .clock   (clock),
      .wr_en   (cmd.col),
      .wr_addr (b_ff),
      .wr_data (colrun),
      .rd_addr (hi_in),
      .rd_data (hi_rd)
   );

   assign lo_val  = (lo_ff == '0) ? '0 : lo_rd;
   assign hi_val  = (hi_ff == '0) ? '0 : hi_rd;
   assign lo_step = (lo_ff < b_ff) && (WANT_W'(lo_val) < want_ff);
   assign hi_step = (hi_ff < b_ff) && (WANT_W'(hi_val) <= want_ff);
   assign pair_end  = (b_ff == n);
   assign sweep_end = (top_ff == n) && (bot_ff == n);

   always_comb begin
      grid_in      = grid_ff;
      target_in    = target_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rowsum_in    = rowsum_ff;
      b_in         = b_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      want_in      = want_ff;
      total_in     = total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_SIZE: begin
               grid_in = GRID_W'(csr_write_data);
               row_in  = '0;
               col_in  = '0;
            end
            CSR_TARGET_SUM: target_in = TARGET_W'(csr_write_data);
            default: ;
         endcase
      end

      if (cmd.load_read) begin
         rowsum_in = (col_ff == '0) ? PREFIX_W'(req_cell_digit)
                                    : PREFIX_W'(rowsum_ff + PREFIX_W'(req_cell_digit));
      end

      if (cmd.load_write) begin
         if (NW'(col_ff) == n - NW'(1)) begin
            col_in = '0;
            row_in = (NW'(row_ff) == n - NW'(1)) ? '0 : RW'(row_ff + RW'(1));
         end else begin
            col_in = RW'(col_ff + RW'(1));
         end
         top_in   = NW'(1);
         bot_in   = NW'(1);
         b_in     = NW'(1);
         lo_in    = '0;
         hi_in    = '0;
         total_in = '0;
      end

      if (cmd.col) begin
         want_in = WANT_W'(colrun) - $signed({2'b00, target_ff});
      end

      if (cmd.lo_run && lo_step) begin
         lo_in = NW'(lo_ff + NW'(1));
      end

      if (cmd.hi_run) begin
         if (hi_step) begin
            hi_in = NW'(hi_ff + NW'(1));
         end else begin
            if (hi_ff > lo_ff) begin
               total_in = COUNT_W'(total_ff + COUNT_W'(hi_ff - lo_ff));
            end
            lo_in = '0;
            hi_in = '0;
            if (pair_end) begin
               b_in = NW'(1);
               if (bot_ff == n) begin
                  top_in = NW'(top_ff + NW'(1));
                  bot_in = NW'(top_ff + NW'(1));
               end else begin
                  bot_in = NW'(bot_ff + NW'(1));
               end
            end else begin
               b_in  = NW'(b_ff + NW'(1));
               lo_in = lo_ff;
               hi_in = hi_ff;
            end
         end
      end

      if (cmd.out_load) begin
         rsp_count_in = total_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff      <= GRID_RESET;
         target_ff    <= TARGET_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         b_ff         <= NW'(1);
         lo_ff        <= '0;
         hi_ff        <= '0;
         top_ff       <= NW'(1);
         bot_ff       <= NW'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_ff      <= grid_in;
         target_ff    <= target_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         b_ff         <= b_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         top_ff       <= top_in;
         bot_ff       <= bot_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rowsum_ff    <= rowsum_in;
      want_ff      <= want_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      sts           = '0;
      sts.last_cell = (NW'(row_ff) == n - NW'(1)) && (NW'(col_ff) == n - NW'(1));
      sts.lo_step   = lo_step;
      sts.hi_step   = hi_step;
      sts.pair_end  = pair_end;
      sts.sweep_end = sweep_end;
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;

   a_lo_bound: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= b_ff)
      else $error("low pointer past column");

   a_hi_bound: assert property (@(posedge clock) disable iff (reset)
      hi_ff <= b_ff)
      else $error("high pointer past column");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      top_ff <= bot_ff)
      else $error("row pair out of order");

endmodule

// ===== rtl/count_subrectangles_with_sum_unit.sv =====
// Top level of the sub-rectangle sum counter.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cell_digit
//   rsp      out        rsp_valid/rsp_stall  rsp_match_count
//   csr      in         csr_write_en         csr_index, csr_write_data
//
// Each cell takes a prefix-table read of the row above, then the write.
// After the last cell the sweep visits n(n+1)/2 row pairs; each pair walks n columns,
// each through the fetch, column, low-pointer and high-pointer states, the last two
// repeating once per pointer advance.
// Reset is synchronous; the prefix table needs no clearing.
// One result may wait on rsp_stall while the next grid loads.
module count_subrectangles_with_sum_unit #(
   parameter int GRID_MAX = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [csws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csws_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [csws_pkg::DIGIT_W-1:0]    req_cell_digit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [csws_pkg::COUNT_W-1:0]    rsp_match_count
);
   import csws_pkg::*;

   cmd_type cmd;
   sts_type sts;

   csws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   csws_dp #(.GRID_MAX(GRID_MAX)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_cell_digit  (req_cell_digit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_count (rsp_match_count),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

// ===== verif/count_subrectangles_with_sum_unit_tb.sv =====
// Self-checking testbench for the sub-rectangle sum counter: directed table, then random grids.
module count_subrectangles_with_sum_unit_tb;
   import csws_pkg::*;

   localparam int GRID_MAX   = 64;
   localparam int CELL_GOAL  = 1850;
   localparam int IDLE_LIMIT = 300000;

   typedef enum int {OP_CELL, OP_GRID, OP_TARGET} op_type;
   typedef struct {
      op_type      op;
      int unsigned val;
      bit          has_exp;
      int unsigned exp;
   } step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GRID_SIZE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DIGIT_W-1:0]    req_cell_digit = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COUNT_W-1:0]    rsp_match_count;

   count_subrectangles_with_sum_unit #(.GRID_MAX(GRID_MAX)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   int unsigned grid_side = 64;
   int unsigned target = 1;
   int unsigned cells_in = 0;
   int unsigned grid_cells [GRID_MAX*GRID_MAX];
   logic [COUNT_W-1:0] count_queue [$];
   int errors = 0;
   int idle_cycles = 0;
   int rsp_hold = 0;
   bit quiet = 1'b0;

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic int gap_len();
      if (quiet || $urandom_range(0, 9) < 7) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [COUNT_W-1:0] count_matches(int unsigned n, int unsigned k);
      int          psum [(GRID_MAX+1)*(GRID_MAX+1)];
      int unsigned total;
      int          s;
      total = 0;
      for (int r = 0; r <= n; r++)
         for (int c = 0; c <= n; c++)
            if (r == 0 || c == 0) psum[r*(GRID_MAX+1)+c] = 0;
            else psum[r*(GRID_MAX+1)+c] = grid_cells[(r-1)*n+c-1]
               + psum[(r-1)*(GRID_MAX+1)+c] + psum[r*(GRID_MAX+1)+c-1]
               - psum[(r-1)*(GRID_MAX+1)+c-1];
      for (int r1 = 0; r1 < n; r1++)
         for (int r2 = r1 + 1; r2 <= n; r2++)
            for (int c1 = 0; c1 < n; c1++)
               for (int c2 = c1 + 1; c2 <= n; c2++) begin
                  s = psum[r2*(GRID_MAX+1)+c2] - psum[r1*(GRID_MAX+1)+c2]
                     - psum[r2*(GRID_MAX+1)+c1] + psum[r1*(GRID_MAX+1)+c1];
                  if (s == k) total++;
               end
      return total[COUNT_W-1:0];
   endfunction

   // returns 1 when this cell completes the grid
   function automatic bit take_cell(int unsigned d, output logic [COUNT_W-1:0] cnt);
      if (cells_in >= grid_side * grid_side) cells_in = 0;
      grid_cells[cells_in] = d & 4'hF;
      cells_in++;
      cnt = '0;
      if (cells_in < grid_side * grid_side) return 1'b0;
      cnt = count_matches(grid_side, target);
      cells_in = 0;
      return 1'b1;
   endfunction

   task automatic wait_idle();
      while (count_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned v);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_GRID_SIZE) begin
         grid_side = v & 7'h7F;
         if (grid_side < 1) grid_side = 1;
         if (grid_side > GRID_MAX) grid_side = GRID_MAX;
         cells_in = 0;
      end else begin
         target = v & 16'hFFFF;
      end
   endtask

   task automatic send_cell(int unsigned d, bit has_exp, int unsigned want);
      int                 gap;
      logic [COUNT_W-1:0] cnt;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_digit <= d[DIGIT_W-1:0];
      do @(posedge clock); while (req_stall);
      if (take_cell(d, cnt)) count_queue.push_back(has_exp ? want[COUNT_W-1:0] : cnt);
   endtask

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (count_queue.size() == 0) report_mismatch("unexpected match_count", rsp_match_count, 0);
         else if (rsp_match_count !== count_queue[0])
            report_mismatch("match_count", rsp_match_count, count_queue.pop_front());
         else void'(count_queue.pop_front());
      end
      if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_hold <= gap_len();
      end
   end

   step_type directed [] = '{
      '{OP_CELL, 5, 0, 0},          // partial grid at reset size, dropped below
      '{OP_GRID, 0, 0, 0},          // size zero acts as one
      '{OP_CELL, 0, 1, 0},
      '{OP_TARGET, 0, 0, 0},
      '{OP_CELL, 0, 1, 1},
      '{OP_TARGET, 65535, 0, 0},
      '{OP_CELL, 15, 1, 0},
      '{OP_TARGET, 15, 0, 0},
      '{OP_CELL, 15, 1, 1},
      '{OP_GRID, 127, 0, 0},        // clamps to the maximum side
      '{OP_CELL, 9, 0, 0},
      '{OP_CELL, 3, 0, 0},
      '{OP_GRID, 2, 0, 0},
      '{OP_TARGET, 0, 0, 0},
      '{OP_CELL, 0, 0, 0},
      '{OP_CELL, 0, 0, 0},
      '{OP_CELL, 0, 0, 0},
      '{OP_CELL, 0, 1, 9},
      '{OP_TARGET, 9, 0, 0},
      '{OP_CELL, 9, 0, 0},
      '{OP_CELL, 0, 0, 0},
      '{OP_CELL, 0, 0, 0},
      '{OP_CELL, 9, 0, 0},
      '{OP_GRID, 3, 0, 0},
      '{OP_TARGET, 36864, 0, 0},
      '{OP_CELL, 15, 0, 0},
      '{OP_GRID, 3, 0, 0},
      '{OP_TARGET, 10, 0, 0},
      '{OP_CELL, 1, 0, 0}, '{OP_CELL, 9, 0, 0}, '{OP_CELL, 0, 0, 0},
      '{OP_CELL, 0, 0, 0}, '{OP_CELL, 10, 0, 0}, '{OP_CELL, 5, 0, 0},
      '{OP_CELL, 5, 0, 0}, '{OP_CELL, 0, 0, 0}, '{OP_CELL, 5, 0, 0}
   };

   initial begin
      int unsigned sent;
      int unsigned n;
      int unsigned mode;
      int unsigned d;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sent = 0;
      foreach (directed[i]) begin
         case (directed[i].op)
            OP_GRID: begin
               req_valid <= 1'b0;
               write_csr(CSR_GRID_SIZE, directed[i].val);
            end
            OP_TARGET: begin
               req_valid <= 1'b0;
               write_csr(CSR_TARGET_SUM, directed[i].val);
            end
            default: begin
               send_cell(directed[i].val, directed[i].has_exp, directed[i].exp);
               sent++;
            end
         endcase
      end
      req_valid <= 1'b0;
      while (sent < CELL_GOAL) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (sent > 400 && sent < 700) n = 24;
         else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 14);
         else n = $urandom_range(1, 8);
         // occasionally drop a partial grid by rewriting the size
         if ($urandom_range(0, 7) == 0) begin
            write_csr(CSR_GRID_SIZE, n + 1);
            repeat ($urandom_range(1, 3)) begin
               send_cell($urandom_range(0, 15), 1'b0, 0);
               sent++;
            end
            req_valid <= 1'b0;
         end
         write_csr(CSR_GRID_SIZE, n);
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_TARGET_SUM, 0);
            1:       write_csr(CSR_TARGET_SUM, $urandom_range(0, 9 * n * n));
            2:       write_csr(CSR_TARGET_SUM, $urandom_range(0, 65535));
            default: write_csr(CSR_TARGET_SUM, $urandom_range(0, 20));
         endcase
         mode = $urandom_range(0, 3);
         repeat (n * n) begin
            if (mode == 0) d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
            else if (mode == 1) d = $urandom_range(0, 15);
            else d = $urandom_range(0, 9);
            send_cell(d, 1'b0, 0);
            sent++;
         end
         req_valid <= 1'b0;
      end
      quiet = 1'b0;
      while (count_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== count_subrectangles_with_sum_unit.f =====
rtl/csws_pkg.sv
rtl/csws_ram.sv
rtl/csws_ctrl.sv
rtl/csws_dp.sv
rtl/count_subrectangles_with_sum_unit.sv
verif/count_subrectangles_with_sum_unit_tb.sv
